/* hdl/case_insensitive_substring_find_core_assert.svh */
// assertion helpers shared by the search block
`ifndef CASE_INSENSITIVE_SUBSTRING_FIND_CORE_ASSERT_SVH
`define CASE_INSENSITIVE_SUBSTRING_FIND_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CISF_ASSERT_IMPL(label, a_clk, a_rst_n, ante, cons) \
  label: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |-> (cons)) \
    else $error("cisf assertion failed");

// next-cycle implication, disabled during reset
`define CISF_ASSERT_NEXT(label, a_clk, a_rst_n, ante, cons) \
  label: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |=> (cons)) \
    else $error("cisf assertion failed");

`endif

/* hdl/cisf_pkg.sv */
`timescale 1ns / 1ps

package cisf_pkg;

  localparam int DEF_MAX_PATTERN    = 16;
  localparam int DEF_POSITION_WIDTH = 16;

  localparam int PATTERN_BITS = 128;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_LEN_W    = 5;
  localparam int START_W      = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

  localparam logic [7:0] TERMINATOR      = 8'h00;
  localparam logic [7:0] FOLD_OFFSET     = 8'h20;
  localparam logic [7:0] FOLD_HIGH_LIMIT = 8'hdf;
  localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z    = 8'h7a;

  typedef struct packed {
    logic step;   // non-terminator byte accepted
    logic clear;  // terminator accepted
  } cisf_ctrl_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if ((c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) || (c > FOLD_HIGH_LIMIT)) begin
      r = c - FOLD_OFFSET;
    end
    return r;
  endfunction

endpackage

/* hdl/cisf_cell.sv */
`timescale 1ns / 1ps

module cisf_cell import cisf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cisf_ctrl_t ctrl,
  input  logic [7:0] pat_byte,
  input  logic [7:0] text_fold,
  input  logic       enable,
  input  logic       last,
  input  logic       match_in,
  output logic       match_out,
  output logic       hit
);

  logic match_r;
  logic match_nxt;
  logic eq;

  assign eq        = enable && (fold_upper(pat_byte) == text_fold);
  assign match_nxt = match_in && eq;
  // this cell closes the pattern and the prefix just completed
  assign hit       = match_nxt && last;
  assign match_out = match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctrl.clear) begin
      match_r <= 1'b0;
    end else if (ctrl.step) begin
      match_r <= match_nxt;
    end
  end

endmodule

/* hdl/case_insensitive_substring_find_core.sv */
`timescale 1ns / 1ps
// Case-insensitive substring search over a byte stream.
// Input channel (in_valid / in_stall / in_text_byte): one text byte per
// transaction; a zero byte ends the string. Output channel (out_valid /
// out_stall / out_match_found / out_match_start / out_position_overflow):
// one transaction per string, for its terminating zero byte.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 and
// 1 load pattern bytes 0..7 and 8..15, index 2 the pattern length; cfg_ready
// is always high. Write config only while no string is in progress.
// Throughput: one byte per cycle while in_stall is low, set by the compare-and-shift
// through the row of match cells (one cell per pattern byte).
// Latency: the result appears in the output register the cycle after the
// terminator is accepted.
// in_stall rises only for a terminator byte while an earlier result is still
// held and out_stall is high; other bytes are always taken.
// Reset (synchronous, rst_n low) clears the pattern registers, the search
// state and the output valid flag; the output result fields are not reset.

module case_insensitive_substring_find_core import cisf_pkg::*; #(
  parameter int MAX_PATTERN    = DEF_MAX_PATTERN,
  parameter int POSITION_WIDTH = DEF_POSITION_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_text_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_match_found,
  output logic [START_W-1:0]     out_match_start,
  output logic                   out_position_overflow,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  `include "case_insensitive_substring_find_core_assert.svh"

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int PW    = POSITION_WIDTH;
  localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

  logic [PATTERN_BITS-1:0] pattern_r;
  logic [CFG_LEN_W-1:0]    cfg_len_r;

  logic [LEN_W-1:0] len_cap;
  logic [LEN_W-1:0] eff_len;

  logic [PW-1:0]      byte_count_r, byte_count_nxt;
  logic               sat_r, sat_nxt;
  logic               found_r, found_nxt;
  logic [START_W-1:0] start_r, start_nxt;

  logic               out_valid_r;
  logic               out_found_r;
  logic [START_W-1:0] out_start_r;
  logic               out_ovf_r;

  logic [7:0]             text_fold;
  logic                   in_take;
  logic                   is_term;
  logic                   out_free;
  cisf_ctrl_t             ctrl;
  logic [MAX_PATTERN-1:0] pm_vec;
  logic [MAX_PATTERN-1:0] hit_vec;
  logic                   hit_any;
  logic [PW:0]            idx_plus;
  logic [PW:0]            start_calc;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      cfg_len_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PATTERN_LOW:    pattern_r[CFG_DATA_W-1:0] <= cfg_data;
        CFG_PATTERN_HIGH:   pattern_r[PATTERN_BITS-1:CFG_DATA_W] <= cfg_data;
        CFG_PATTERN_LENGTH: cfg_len_r <= cfg_data[CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // length in use: capped, and cut at the first zero pattern byte
  always_comb begin
    len_cap = (cfg_len_r > CFG_LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                     : LEN_W'(cfg_len_r);
    eff_len = len_cap;
    for (int i = MAX_PATTERN - 1; i >= 0; i--) begin
      if ((LEN_W'(i) < len_cap) && (pattern_r[8*i +: 8] == TERMINATOR)) begin
        eff_len = LEN_W'(i);
      end
    end
  end

  // handshake
  assign is_term    = (in_text_byte == TERMINATOR);
  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = is_term && !out_free;
  assign in_take    = in_valid && !in_stall;
  assign ctrl.step  = in_take && !is_term;
  assign ctrl.clear = in_take && is_term;
  assign text_fold  = fold_upper(in_text_byte);

  // row of match cells
  genvar g;
  generate
    for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
      logic prev;
      if (g == 0) begin : g_head
        assign prev = 1'b1;
      end else begin : g_link
        assign prev = pm_vec[g-1];
      end
      cisf_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .pat_byte  (pattern_r[8*g +: 8]),
        .text_fold (text_fold),
        .enable    (LEN_W'(g) < eff_len),
        .last      (eff_len == LEN_W'(g + 1)),
        .match_in  (prev),
        .match_out (pm_vec[g]),
        .hit       (hit_vec[g])
      );
    end
  endgenerate

  assign hit_any = |hit_vec;

  // start = index + 1 - length
  assign idx_plus   = {1'b0, byte_count_r} + (PW+1)'(1);
  assign start_calc = (idx_plus >= (PW+1)'(eff_len)) ? (idx_plus - (PW+1)'(eff_len))
                                                      : '0;

  always_comb begin
    byte_count_nxt = byte_count_r;
    sat_nxt        = sat_r;
    found_nxt      = found_r;
    start_nxt      = start_r;
    if (ctrl.clear) begin
      byte_count_nxt = '0;
      sat_nxt        = 1'b0;
      found_nxt      = 1'b0;
      start_nxt      = '0;
    end else if (ctrl.step) begin
      if (byte_count_r == POS_MAX) begin
        sat_nxt = 1'b1;
      end else begin
        byte_count_nxt = byte_count_r + PW'(1);
      end
      if (!found_r) begin
        if (eff_len == '0) begin
          found_nxt = 1'b1;
          start_nxt = '0;
        end else if (hit_any) begin
          found_nxt = 1'b1;
          start_nxt = START_W'(start_calc[PW-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      sat_r        <= 1'b0;
      found_r      <= 1'b0;
      start_r      <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      sat_r        <= sat_nxt;
      found_r      <= found_nxt;
      start_r      <= start_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.clear) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      out_found_r <= found_r;
      out_start_r <= found_r ? start_r : '0;
      out_ovf_r   <= sat_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_match_found       = out_found_r;
  assign out_match_start       = out_start_r;
  assign out_position_overflow = out_ovf_r;

  `CISF_ASSERT_IMPL(a_stall_only_pending, clk, rst_n, in_stall, out_valid_r && is_term)
  `CISF_ASSERT_NEXT(a_clear_after_term, clk, rst_n, ctrl.clear,
                    byte_count_r == '0 && pm_vec == '0 && !found_r && !sat_r)
  `CISF_ASSERT_NEXT(a_first_match_kept, clk, rst_n, found_r && ctrl.step,
                    found_r && $stable(start_r))
  `CISF_ASSERT_IMPL(a_sat_holds_max, clk, rst_n, sat_r, byte_count_r == POS_MAX)
  `CISF_ASSERT_NEXT(a_empty_pattern, clk, rst_n, ctrl.step && !found_r && eff_len == '0,
                    found_r && start_r == '0)

endmodule
